// File: rtl/pidl_pkg.sv
// ----------------------------------------------------------------------------
// pidl_pkg
// Shared types, codes and elaboration helpers for the positional list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pidl_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned RADIX   = 8;

  // opcodes; the unused code decodes as read
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  // per-cycle shift command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic del;
  } cell_cmd_t;

  // number of nodes left after lvl rounds of RADIX-way reduction
  function automatic int unsigned level_size(int unsigned n, int unsigned lvl);
    int unsigned s;
    s = n;
    for (int unsigned i = 0; i < lvl; i++) begin
      s = (s + RADIX - 1) / RADIX;
    end
    return s;
  endfunction

  // register levels needed to reduce n leaves to one
  function automatic int unsigned or_levels(int unsigned n);
    int unsigned s;
    int unsigned l;
    s = n;
    l = 0;
    for (int unsigned i = 0; i < 16; i++) begin
      if (s > 1 || l == 0) begin
        s = (s + RADIX - 1) / RADIX;
        l = l + 1;
      end
    end
    return l;
  endfunction

endpackage

`default_nettype wire

// File: rtl/pidl_cell.sv
// ----------------------------------------------------------------------------
// pidl_cell
// One list slot: holds a word and shifts with its neighbors on insert/delete.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pidl_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned PW    = 8
) (
  input  logic                        clk_i,
  input  pidl_pkg::cell_cmd_t         cmd_i,
  input  logic [PW-1:0]               pos_i,
  input  logic [pidl_pkg::WORD_W-1:0] ins_value_i,
  input  logic [pidl_pkg::WORD_W-1:0] left_i,
  input  logic [pidl_pkg::WORD_W-1:0] right_i,
  output logic [pidl_pkg::WORD_W-1:0] data_o,
  output logic [pidl_pkg::WORD_W-1:0] sel_o
);
  import pidl_pkg::*;

  localparam logic [PW-1:0] Idx = PW'(INDEX);

  logic [WORD_W-1:0] data_q, data_d;
  logic              hit, above;

  assign hit   = (Idx == pos_i);
  assign above = (Idx > pos_i);

  always_comb begin
    data_d = data_q;
    if (cmd_i.ins) begin
      if (above) begin
        data_d = left_i;
      end else if (hit) begin
        data_d = ins_value_i;
      end
    end else if (cmd_i.del) begin
      if (hit || above) begin
        data_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign sel_o  = hit ? data_q : '0;

endmodule

`default_nettype wire

// File: rtl/pidl_or_tree.sv
// ----------------------------------------------------------------------------
// pidl_or_tree
// Registered 8-way OR reduction of the one-hot cell selects; one level a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pidl_or_tree #(
  parameter int unsigned DEPTH  = 128,
  parameter int unsigned LEVELS = 3
) (
  input  logic                                   clk_i,
  input  logic [LEVELS-1:0]                      en_i,
  input  logic [DEPTH-1:0][pidl_pkg::WORD_W-1:0] leaves_i,
  output logic [pidl_pkg::WORD_W-1:0]            root_o
);
  import pidl_pkg::*;

  localparam int unsigned L1 = level_size(DEPTH, 1);

  logic [WORD_W-1:0] lvl_q [LEVELS][L1];

  for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
    localparam int unsigned NIn  = level_size(DEPTH, l);
    localparam int unsigned NOut = level_size(DEPTH, l + 1);
    for (genvar j = 0; j < NOut; j++) begin : g_node
      logic [WORD_W-1:0] acc;
      always_comb begin
        acc = '0;
        for (int unsigned k = 0; k < RADIX; k++) begin
          if (j * RADIX + k < NIn) begin
            if (l == 0) begin
              acc = acc | leaves_i[j*RADIX+k];
            end else begin
              acc = acc | lvl_q[(l > 0) ? l - 1 : 0][j*RADIX+k];
            end
          end
        end
      end
      always_ff @(posedge clk_i) begin
        if (en_i[l]) begin
          lvl_q[l][j] <= acc;
        end
      end
    end
  end

  assign root_o = lvl_q[LEVELS-1][0];

endmodule

`default_nettype wire

// File: rtl/positional_insert_delete_list_top.sv
// ----------------------------------------------------------------------------
// positional_insert_delete_list_top
// Ordered list of up to DEPTH words with insert, delete and read by position.
// ----------------------------------------------------------------------------
// Each operation runs through LEVELS = ceil(log8(DEPTH)) tree levels to its
// result: the list lives in a row of cells that shifts the entries at and
// above the addressed position in the transfer cycle, and the addressed word
// is collected through a registered 8-way OR tree, one level per cycle. A
// result waiting in the output register does not hold up its successor until
// that one is ready to leave. No clearing pass follows reset; only the count
// is cleared, and entries at or above the count are never returned.
`timescale 1ns / 1ps
`default_nettype none

module positional_insert_delete_list_top #(
  parameter int unsigned DEPTH = 128
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  opcode_i,
  input  logic [pidl_pkg::POS_W-1:0]  position_i,
  input  logic [pidl_pkg::WORD_W-1:0] value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [pidl_pkg::WORD_W-1:0] read_value_o,
  output logic [1:0]                  status_o,
  output logic [pidl_pkg::POS_W-1:0]  entry_count_o,
  output logic                        is_full_o,
  output logic                        is_empty_o
);
  import pidl_pkg::*;

  localparam int unsigned CW        = $clog2(DEPTH + 1);
  localparam int unsigned PW        = (CW > POS_W) ? CW : POS_W;
  localparam int unsigned NumLevels = or_levels(DEPTH);

  logic                          accept, load_out, ok;
  logic [1:0]                    status_d;
  logic                          take_d;
  logic [PW-1:0]                 pos_ext, cnt_ext;
  logic [CW-1:0]                 count_q, count_d;
  logic [1:0]                    status_q;
  logic                          take_q;
  logic                          busy_q, done_q, out_valid_q;
  logic [NumLevels-1:0]          vld_q, vld_d;
  cell_cmd_t                     cmd;
  logic [DEPTH-1:0][WORD_W-1:0]  cell_data, cell_sel;
  logic [WORD_W-1:0]             root;
  logic [WORD_W-1:0]             rd_q;
  logic [1:0]                    st_q;
  logic [CW-1:0]                 cnt_out_q;

  assign accept     = in_valid_i && !busy_q;
  assign in_stall_o = busy_q;
  assign load_out   = done_q && (!out_valid_q || !out_stall_i);

  assign pos_ext = PW'(position_i);
  assign cnt_ext = PW'(count_q);

  always_comb begin
    status_d = ST_OK;
    take_d   = 1'b0;
    if (opcode_i == OP_INSERT) begin
      if (count_q == CW'(DEPTH)) begin
        status_d = ST_FULL;
      end else if (pos_ext > cnt_ext) begin
        status_d = ST_RANGE;
      end
    end else if (count_q == '0) begin
      status_d = ST_EMPTY;
    end else if (pos_ext >= cnt_ext) begin
      status_d = ST_RANGE;
    end else begin
      take_d = 1'b1;
    end
  end

  assign ok      = (status_d == ST_OK);
  assign cmd.ins = accept && ok && (opcode_i == OP_INSERT);
  assign cmd.del = accept && ok && (opcode_i == OP_DELETE);

  always_comb begin
    count_d = count_q;
    if (cmd.ins) begin
      count_d = count_q + CW'(1);
    end else if (cmd.del) begin
      count_d = count_q - CW'(1);
    end
  end

  // stage strobes of the read tree; level 0 loads with the transfer
  always_comb begin
    vld_d[0] = accept;
    for (int unsigned l = 1; l < NumLevels; l++) begin
      vld_d[l] = vld_q[l-1];
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end
    pidl_cell #(
      .INDEX (i),
      .PW    (PW)
    ) u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .pos_i       (pos_ext),
      .ins_value_i (value_i),
      .left_i      (left),
      .right_i     (right),
      .data_o      (cell_data[i]),
      .sel_o       (cell_sel[i])
    );
  end

  pidl_or_tree #(
    .DEPTH  (DEPTH),
    .LEVELS (NumLevels)
  ) u_tree (
    .clk_i    (clk_i),
    .en_i     (vld_d),
    .leaves_i (cell_sel),
    .root_o   (root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      busy_q      <= 1'b0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
      vld_q       <= '0;
    end else begin
      count_q <= count_d;
      vld_q   <= vld_d;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (load_out) begin
        busy_q <= 1'b0;
      end
      if (vld_q[NumLevels-1]) begin
        done_q <= 1'b1;
      end else if (load_out) begin
        done_q <= 1'b0;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      take_q   <= take_d;
    end
    if (load_out) begin
      rd_q      <= take_q ? root : '0;
      st_q      <= status_q;
      cnt_out_q <= count_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_value_o  = rd_q;
  assign status_o      = st_q;
  assign entry_count_o = POS_W'(cnt_out_q);
  assign is_full_o     = (cnt_out_q == CW'(DEPTH));
  assign is_empty_o    = (cnt_out_q == '0);

endmodule

`default_nettype wire

// File: rtl/pidl_checker.sv
// ----------------------------------------------------------------------------
// pidl_checker
// Port-level assertions for the positional list, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pidl_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_stall_o,
  input wire logic [1:0]                  opcode_i,
  input wire logic [pidl_pkg::POS_W-1:0]  position_i,
  input wire logic [pidl_pkg::WORD_W-1:0] value_i,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire logic [pidl_pkg::WORD_W-1:0] read_value_o,
  input wire logic [1:0]                  status_o,
  input wire logic [pidl_pkg::POS_W-1:0]  entry_count_o,
  input wire logic                        is_full_o,
  input wire logic                        is_empty_o
);
  import pidl_pkg::*;

  // a stalled input transfer keeps its payload
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(opcode_i)
      && $stable(position_i) && $stable(value_i))
    else $error("stalled input changed");

  // a result held under stall keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(read_value_o)
      && $stable(status_o) && $stable(entry_count_o))
    else $error("stalled result changed");

  // one operation in flight: a transfer closes the input for the next cycle
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while busy");

  // error codes agree with the reported flags
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(is_full_o && is_empty_o)
      && (status_o != ST_FULL || is_full_o)
      && (status_o != ST_EMPTY || is_empty_o)
      && (is_empty_o == (entry_count_o == '0)))
    else $error("status and flags disagree");

  // a nonzero word is returned only with an ok status
  a_rd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (read_value_o != '0) |-> status_o == ST_OK)
    else $error("word returned on error");

endmodule

bind positional_insert_delete_list_top pidl_checker u_pidl_checker (.*);

`default_nettype wire

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for positional_insert_delete_list_top.
// ----------------------------------------------------------------------------
// A queue of list operations feeds a clocked driver. Every input transfer is
// run through a shadow copy of the list, and the expected result is queued.
// A clocked monitor checks each output transfer against the oldest
// expectation. Stimulus is a short directed run, then bursts that fill, drain
// or churn the list. The bursts go through three idling phases. A long
// output hold backs up the pipe, and between phases the sender waits for
// the pipe to drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  import pidl_pkg::*;

  localparam int unsigned LIST_DEPTH = 128;
  localparam logic [1:0]  OP_SPARE   = 2'd3;   // undefined code, acts as read
  localparam int          STALL_LIMIT = 4000;
  localparam int          LONG_HOLD   = 300;
  localparam int          PHASE_ITEMS = 625;

  typedef struct {
    logic [1:0]        op;
    logic [POS_W-1:0]  pos;
    logic [WORD_W-1:0] val;
  } list_op_t;

  typedef struct {
    logic [WORD_W-1:0] rd;
    logic [1:0]        st;
    logic [POS_W-1:0]  cnt;
    logic              full;
    logic              empty;
  } list_result_t;

  typedef enum {BURST_FILL, BURST_DRAIN, BURST_CHURN} burst_kind_e;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [1:0]          opcode_i = OP_READ;
  logic [POS_W-1:0]    position_i = '0;
  logic [WORD_W-1:0]   value_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [WORD_W-1:0]   read_value_o;
  logic [1:0]          status_o;
  logic [POS_W-1:0]    entry_count_o;
  logic                is_full_o;
  logic                is_empty_o;

  list_op_t     pending_ops[$];
  list_result_t expected_results[$];

  // shadow list, updated on every input transfer
  logic [WORD_W-1:0] shadow_words [0:LIST_DEPTH-1];
  int                shadow_count = 0;

  // count as the generator sees it, ahead of the shadow list
  int          gen_count = 0;
  burst_kind_e burst_kind = BURST_FILL;
  int          burst_left = 0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int fail_cnt = 0;
  int quiet_cycles = 0;

  positional_insert_delete_list_top #(
    .DEPTH(LIST_DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .position_i   (position_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_value_o (read_value_o),
    .status_o     (status_o),
    .entry_count_o(entry_count_o),
    .is_full_o    (is_full_o),
    .is_empty_o   (is_empty_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  task automatic predict_list_op(input logic [1:0] op, input logic [POS_W-1:0] pos,
                                 input logic [WORD_W-1:0] val);
    list_result_t res;
    int i;
    res.rd = '0;
    res.st = ST_OK;
    if (op == OP_INSERT) begin
      // full wins over a bad position
      if (shadow_count >= LIST_DEPTH) begin
        res.st = ST_FULL;
      end else if (pos > shadow_count) begin
        res.st = ST_RANGE;
      end else begin
        for (i = shadow_count; i > pos; i--) shadow_words[i] = shadow_words[i-1];
        shadow_words[pos] = val;
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      res.st = ST_EMPTY;
    end else if (pos >= shadow_count) begin
      res.st = ST_RANGE;
    end else begin
      res.rd = shadow_words[pos];
      if (op == OP_DELETE) begin
        for (i = pos; i + 1 < shadow_count; i++) shadow_words[i] = shadow_words[i+1];
        shadow_count--;
      end
    end
    res.cnt   = shadow_count[POS_W-1:0];
    res.full  = (shadow_count == LIST_DEPTH);
    res.empty = (shadow_count == 0);
    expected_results.push_back(res);
  endtask

  task automatic queue_op(input logic [1:0] op, input logic [POS_W-1:0] pos,
                          input logic [WORD_W-1:0] val);
    list_op_t item;
    item.op  = op;
    item.pos = pos;
    item.val = val;
    pending_ops.push_back(item);
    if (op == OP_INSERT) begin
      if (gen_count < LIST_DEPTH && pos <= gen_count) gen_count++;
    end else if (op == OP_DELETE) begin
      if (gen_count > 0 && pos < gen_count) gen_count--;
    end
  endtask

  task automatic queue_random_op();
    int r;
    int p;
    logic [1:0]        op;
    logic [POS_W-1:0]  pos;
    logic [WORD_W-1:0] val;
    if (burst_left == 0) begin
      burst_left = $urandom_range(280, 180);
      case (burst_kind)
        BURST_FILL:  burst_kind = BURST_CHURN;
        BURST_CHURN: burst_kind = BURST_DRAIN;
        default:     burst_kind = BURST_FILL;
      endcase
    end
    burst_left--;
    r = $urandom_range(99);
    case (burst_kind)
      BURST_FILL: begin
        op = (r < 75) ? OP_INSERT : (r < 85) ? OP_DELETE : (r < 98) ? OP_READ : OP_SPARE;
      end
      BURST_DRAIN: begin
        op = (r < 10) ? OP_INSERT : (r < 80) ? OP_DELETE : (r < 98) ? OP_READ : OP_SPARE;
      end
      default: begin
        op = (r < 40) ? OP_INSERT : (r < 70) ? OP_DELETE : (r < 97) ? OP_READ : OP_SPARE;
      end
    endcase
    p = $urandom_range(99);
    if (p < 8) begin
      pos = POS_W'($urandom_range(255));
    end else if (p < 16) begin
      // just past the legal range
      pos = (op == OP_INSERT) ? POS_W'(gen_count + 1) : POS_W'(gen_count);
    end else if (op == OP_INSERT) begin
      pos = (p < 30) ? '0 : (p < 44) ? POS_W'(gen_count) :
            POS_W'($urandom_range(gen_count));
    end else if (gen_count == 0) begin
      pos = '0;
    end else begin
      pos = (p < 30) ? '0 : (p < 44) ? POS_W'(gen_count - 1) :
            POS_W'($urandom_range(gen_count - 1));
    end
    r = $urandom_range(99);
    val = (r < 5) ? '0 : (r < 10) ? '1 : $urandom;
    queue_op(op, pos, val);
  endtask

  task automatic queue_phase(input int n);
    repeat (n) queue_random_op();
  endtask

  // sender pause: nothing queued, nothing offered, nothing outstanding
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_ops.size() != 0 || in_valid_i || expected_results.size() != 0);
  endtask

  // driver
  always @(posedge clk_i) begin
    list_op_t nxt;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) predict_list_op(opcode_i, position_i, value_i);
      if (!in_valid_i || !in_stall_o) begin
        if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_ops.pop_front();
          opcode_i   <= nxt.op;
          position_i <= nxt.pos;
          value_i    <= nxt.val;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with an occasional long hold
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    list_result_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10) begin
          $display("unexpected result transfer: value %h status %0d count %0d",
                   read_value_o, status_o, entry_count_o);
        end
      end else begin
        exp_res = expected_results.pop_front();
        if (read_value_o !== exp_res.rd || status_o !== exp_res.st ||
            entry_count_o !== exp_res.cnt || is_full_o !== exp_res.full ||
            is_empty_o !== exp_res.empty) begin
          fail_cnt++;
          if (fail_cnt <= 10) begin
            $display("mismatch: exp value %h status %0d count %0d full %b empty %b",
                     exp_res.rd, exp_res.st, exp_res.cnt, exp_res.full, exp_res.empty);
            $display("          got value %h status %0d count %0d full %b empty %b",
                     read_value_o, status_o, entry_count_o, is_full_o, is_empty_o);
          end
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout after %0d cycles without a transfer", quiet_cycles);
        $display("positional_insert_delete_list_top test failed");
        $finish;
      end
    end
  end

  initial begin
    // nonblocking so the falling reset edge reaches every register process
    rst_ni <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = 8;
    recv_idle_pct = 69;

    // empty list: empty status wins over any position for reads and deletes; inserts past the end get a range error
    queue_op(OP_READ,   8'd0,   32'h1234_5678);
    queue_op(OP_DELETE, 8'd255, 32'h0);
    queue_op(OP_SPARE,  8'd0,   32'h0);
    queue_op(OP_INSERT, 8'd1,   32'hDEAD_BEEF);
    queue_op(OP_INSERT, 8'd255, 32'hFFFF_FFFF);
    // build: front, append, middle
    queue_op(OP_INSERT, 8'd0,   32'h0000_0000);
    queue_op(OP_INSERT, 8'd1,   32'hFFFF_FFFF);
    queue_op(OP_INSERT, 8'd0,   32'hA5A5_A5A5);
    queue_op(OP_INSERT, 8'd1,   32'h5A5A_5A5A);
    queue_op(OP_READ,   8'd0,   32'h0);
    queue_op(OP_READ,   8'd3,   32'h0);
    queue_op(OP_READ,   8'd4,   32'h0);
    queue_op(OP_SPARE,  8'd2,   32'h0);
    queue_op(OP_DELETE, 8'd4,   32'h0);
    queue_op(OP_READ,   8'd255, 32'h0);
    // delete middle, last, front
    queue_op(OP_DELETE, 8'd1,   32'h0);
    queue_op(OP_DELETE, 8'd2,   32'h0);
    queue_op(OP_DELETE, 8'd0,   32'h0);
    queue_op(OP_READ,   8'd0,   32'h0);
    queue_op(OP_DELETE, 8'd0,   32'h0);
    queue_op(OP_DELETE, 8'd0,   32'h0);
    queue_op(OP_INSERT, 8'd0,   32'h8000_0001);
    queue_op(OP_INSERT, 8'd2,   32'h7FFF_FFFE);

    queue_phase(PHASE_ITEMS);
    wait_drained();

    send_idle_pct = 69;
    recv_idle_pct = 8;
    queue_phase(PHASE_ITEMS);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_phase(PHASE_ITEMS);
    hold_req++;
    wait_drained();

    repeat (20) @(negedge clk_i);
    if (fail_cnt == 0 && expected_results.size() == 0) begin
      $display("positional_insert_delete_list_top test passed");
    end else begin
      $display("positional_insert_delete_list_top test failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/pidl_pkg.sv
rtl/pidl_cell.sv
rtl/pidl_or_tree.sv
rtl/positional_insert_delete_list_top.sv
rtl/pidl_checker.sv
bench/tb_top.sv
